// ----- design/wam_pkg.sv -----
// Shared widths, types and defaults for the sliding-window mean/max/min block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wam_pkg;

  // Ring depth default for the top level parameter
  localparam int WINDOW_MAX_DEFAULT = 256;

  localparam int AXES     = 3;
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 9;
  localparam int ENTRY_W  = AXES * SAMPLE_W;
  // Window sum: up to 511 samples of 16 bits
  localparam int SUM_W    = SAMPLE_W + LEN_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [LEN_W-1:0]    len_t;

endpackage

// ----- design/window_average_max_min_unit.sv -----
// Channel   | Handshake                 | Payload
// config    | cfg_write (no wait)       | cfg_data: window length, 9 bits
// sample in | in_valid / in_ready       | sample_x, sample_y, sample_z
// result    | out_valid / out_ready     | oldest_*, mean_*, peak_*, floor_*
//
// Each beat is written to the ring; once the window is full the ring is read
// one entry per cycle (n entries, n the effective length) through the single
// read port, then the shared divider works through the axes in turn: a result
// is loaded once the last axis is done and in_ready returns on the same edge.
// A result waiting in the output register stalls only the end of the next item.
// Synchronous reset clears control state; the ring contents are not cleared.
// Top level of the block; depends on wam_pkg, wam_window and wam_divider.
`timescale 1ns / 1ps

module window_average_max_min_unit
  import wam_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  len_t       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  sample_t    sample_x,
  input  sample_t    sample_y,
  input  sample_t    sample_z,
  output logic       out_valid,
  input  logic       out_ready,
  output sample_t    oldest_x,
  output sample_t    oldest_y,
  output sample_t    oldest_z,
  output sample_t    mean_x,
  output sample_t    mean_y,
  output sample_t    mean_z,
  output sample_t    peak_x,
  output sample_t    peak_y,
  output sample_t    peak_z,
  output sample_t    floor_x,
  output sample_t    floor_y,
  output sample_t    floor_z
);

  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LIMIT = (WINDOW_MAX > (1 << LEN_W) - 1) ? (1 << LEN_W) - 1 : WINDOW_MAX;
  localparam int PW    = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LIMIT);
  localparam logic [AW-1:0]    LAST_POS  = AW'(WINDOW_MAX - 1);
  localparam logic [1:0]       LAST_AXIS = 2'(AXES - 1);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    DRAIN,
    DIV_GO,
    DIV_WAIT,
    EMIT
  } state_t;

  state_t          state;
  len_t            window_length;
  logic [AW-1:0]   write_position;
  len_t            fill_count;

  logic [AW-1:0]   rd_addr;
  len_t            issue_left;
  logic            rd_pending;
  logic            first;
  logic [1:0]      axis;

  sum_t            sum_acc [AXES];
  sample_t         hi_acc  [AXES];
  sample_t         lo_acc  [AXES];
  sample_t         old_acc [AXES];
  sample_t         mean_r  [AXES];

  len_t            eff_len;
  len_t            fill_next;
  logic            accept;
  logic [PW-1:0]   pos_w;
  logic [PW-1:0]   back;
  logic [AW-1:0]   oldest_pos;
  logic [AW-1:0]   rd_addr_next;
  logic [ENTRY_W-1:0] rd_data;
  sample_t         rd_val  [AXES];
  logic            div_done;
  sample_t         div_quo;

  // effective window length: zero reads as one, clamped to the ring depth and to at most 511
  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (window_length > LEN_LIMIT) begin
      eff_len = LEN_LIMIT;
    end else begin
      eff_len = window_length;
    end
  end

  assign in_ready  = (state == IDLE);
  assign accept    = in_valid && in_ready;
  assign fill_next = (fill_count < eff_len) ? fill_count + 1'b1 : fill_count;

  // oldest slot of the window, counted back from the slot being written
  assign pos_w = PW'(write_position);
  assign back  = PW'(eff_len - 1'b1);
  assign oldest_pos = (pos_w >= back) ? AW'(pos_w - back)
                                      : AW'(pos_w + PW'(WINDOW_MAX) - back);

  assign rd_addr_next = (rd_addr == LAST_POS) ? '0 : rd_addr + 1'b1;

  // ring storage
  wam_window #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_window (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (write_position),
    .wr_data ({sample_z, sample_y, sample_x}),
    .rd_en   (state == SCAN),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rd_val[a] = sample_t'(rd_data[a*SAMPLE_W +: SAMPLE_W]);
    end
  end

  // shared divider, one axis at a time
  wam_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (state == DIV_GO),
    .dividend (sum_acc[axis]),
    .divisor  (eff_len),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      window_length  <= LEN_RESET;
      write_position <= '0;
      fill_count     <= '0;
      rd_pending     <= 1'b0;
      out_valid      <= 1'b0;
      axis           <= '0;
    end else begin
      rd_pending <= (state == SCAN);

      // result taken; EMIT reloads the register itself
      if (out_valid && out_ready && (state != EMIT)) begin
        out_valid <= 1'b0;
      end

      // accumulate the entry read last cycle
      if (rd_pending) begin
        first <= 1'b0;
        for (int a = 0; a < AXES; a++) begin
          if (first) begin
            sum_acc[a] <= {{(SUM_W-SAMPLE_W){rd_val[a][SAMPLE_W-1]}}, rd_val[a]};
            hi_acc[a]  <= rd_val[a];
            lo_acc[a]  <= rd_val[a];
            old_acc[a] <= rd_val[a];
          end else begin
            sum_acc[a] <= sum_acc[a]
                          + {{(SUM_W-SAMPLE_W){rd_val[a][SAMPLE_W-1]}}, rd_val[a]};
            if (rd_val[a] > hi_acc[a]) begin
              hi_acc[a] <= rd_val[a];
            end
            if (rd_val[a] < lo_acc[a]) begin
              lo_acc[a] <= rd_val[a];
            end
          end
        end
      end

      case (state)
        IDLE: begin
          if (cfg_write) begin
            // new length: window fills again from empty
            window_length  <= cfg_data;
            fill_count     <= '0;
            write_position <= '0;
          end else if (accept) begin
            write_position <= (write_position == LAST_POS) ? '0 : write_position + 1'b1;
            fill_count     <= fill_next;
            if (fill_next == eff_len) begin
              rd_addr    <= oldest_pos;
              issue_left <= eff_len;
              first      <= 1'b1;
              state      <= SCAN;
            end
          end
        end
        SCAN: begin
          rd_addr    <= rd_addr_next;
          issue_left <= issue_left - 1'b1;
          if (issue_left == LEN_W'(1)) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          axis  <= '0;
          state <= DIV_GO;
        end
        DIV_GO: begin
          state <= DIV_WAIT;
        end
        DIV_WAIT: begin
          if (div_done) begin
            mean_r[axis] <= div_quo;
            if (axis == LAST_AXIS) begin
              state <= EMIT;
            end else begin
              axis  <= axis + 1'b1;
              state <= DIV_GO;
            end
          end
        end
        EMIT: begin
          // load the output register once it is free or being emptied
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            oldest_x  <= old_acc[0];
            oldest_y  <= old_acc[1];
            oldest_z  <= old_acc[2];
            mean_x    <= mean_r[0];
            mean_y    <= mean_r[1];
            mean_z    <= mean_r[2];
            peak_x    <= hi_acc[0];
            peak_y    <= hi_acc[1];
            peak_z    <= hi_acc[2];
            floor_x   <= lo_acc[0];
            floor_y   <= lo_acc[1];
            floor_z   <= lo_acc[2];
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/wam_window.sv -----
// Sample ring storage: one write port, one read port with registered read data.
// Depends on wam_pkg for the entry width.
`timescale 1ns / 1ps

module wam_window
  import wam_pkg::*;
#(
  parameter int DEPTH = WINDOW_MAX_DEFAULT,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered: data appears in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/wam_divider.sv -----
// Shared restoring divider: signed window sum over unsigned length, one quotient
// bit per cycle, truncated toward zero. Depends on wam_pkg.
`timescale 1ns / 1ps

module wam_divider
  import wam_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  sum_t    dividend,
  input  len_t    divisor,
  output logic    done,
  output sample_t quotient
);

  localparam int CW = $clog2(SUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic             neg;
  logic [SUM_W-1:0] quo;
  logic [LEN_W-1:0] rem;

  logic [SUM_W-1:0] mag;
  logic [LEN_W:0]   trial;
  logic             fits;
  logic [SUM_W-1:0] quo_signed;

  // magnitude of the dividend at start
  assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

  // one restoring step
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // quotient sign restored; the mean always fits the sample width
  assign quo_signed = neg ? (~quo + 1'b1) : quo;
  assign quotient   = sample_t'(quo_signed[SAMPLE_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SUM_W);
        neg  <= dividend[SUM_W-1];
        quo  <= mag;
        rem  <= '0;
      end else if (busy) begin
        rem <= fits ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
        quo <= {quo[SUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
